/* sv/spicrm_pkg.sv */
// Shared types, register indexes and constants of the SPI controller register model.
package spicrm_pkg;

  // Receive buffer geometry and slave count.
  localparam int unsigned FIFO_DEPTH  = 1024;
  localparam int unsigned PTR_W       = $clog2(FIFO_DEPTH);
  localparam int unsigned FILL_W      = PTR_W + 1;
  localparam int unsigned SLAVE_COUNT = 8;
  localparam int unsigned NREGS       = 22;

  // Dense register indexes.
  localparam logic [4:0] R_GCR0    = 5'd0;
  localparam logic [4:0] R_GCR1    = 5'd1;
  localparam logic [4:0] R_INT0    = 5'd2;
  localparam logic [4:0] R_FLG     = 5'd4;
  localparam logic [4:0] R_PC3     = 5'd8;
  localparam logic [4:0] R_PC4     = 5'd9;
  localparam logic [4:0] R_PC5     = 5'd10;
  localparam logic [4:0] R_DAT0    = 5'd11;
  localparam logic [4:0] R_DAT1    = 5'd12;
  localparam logic [4:0] R_BUF     = 5'd13;
  localparam logic [4:0] R_DEF     = 5'd16;
  localparam logic [4:0] R_FMT0    = 5'd17;
  localparam logic [4:0] R_INTVEC1 = 5'd21;

  // Interrupt vector codes and defaults.
  localparam logic [31:0] VEC_TX      = 32'h0000_0028;
  localparam logic [31:0] VEC_RX      = 32'h0000_0024;
  localparam logic [31:0] DEF_RESET   = 32'h0000_00FF;
  localparam logic [3:0]  SLAVE_NONE  = 4'd8;

  // Input mode codes.
  localparam logic [2:0] MODE_READ   = 3'd0;
  localparam logic [2:0] MODE_WRITE  = 3'd1;
  localparam logic [2:0] MODE_BYTE   = 3'd2;
  localparam logic [2:0] MODE_RX     = 3'd3;
  localparam logic [2:0] MODE_RXEND  = 3'd4;

  typedef enum logic [2:0] {
    KIND_READ,
    KIND_WRITE,
    KIND_BYTE,
    KIND_RX,
    KIND_RXEND,
    KIND_NONE
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [4:0]  addr;
    logic [1:0]  lane;
    logic [31:0] data;
  } item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_raised;
    logic        cs_assert;
    logic        cs_deassert;
    logic        tx_valid;
    logic [15:0] tx_data;
    logic [1:0]  tx_byte_count;
    logic        transmit_done;
    logic [3:0]  slave_select;
  } result_t;

  typedef enum logic {
    ST_FETCH,
    ST_EXEC
  } phase_e;

endpackage

/* sv/spicrm_front.sv */
// Front end: accepts bus events, classifies them and queues them for the back end.
module spicrm_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [2:0]          in_mode_i,
  input  logic [4:0]          in_addr_i,
  input  logic [1:0]          in_lane_i,
  input  logic [31:0]         in_data_i,
  output logic                item_valid_o,
  input  logic                item_pop_i,
  output spicrm_pkg::item_t   item_o
);

  spicrm_pkg::item_t queue_q [2];
  logic              head_q, head_d;
  logic              tail_q, tail_d;
  logic [1:0]        count_q, count_d;
  spicrm_pkg::item_t cls;
  logic              push;

  // Decode the mode into an operation kind.
  always_comb begin
    cls.addr = in_addr_i;
    cls.lane = in_lane_i;
    cls.data = in_data_i;
    unique case (in_mode_i)
      spicrm_pkg::MODE_READ:  cls.kind = spicrm_pkg::KIND_READ;
      spicrm_pkg::MODE_WRITE: cls.kind = spicrm_pkg::KIND_WRITE;
      spicrm_pkg::MODE_BYTE:  cls.kind = spicrm_pkg::KIND_BYTE;
      spicrm_pkg::MODE_RX:    cls.kind = spicrm_pkg::KIND_RX;
      spicrm_pkg::MODE_RXEND: cls.kind = spicrm_pkg::KIND_RXEND;
      default:                cls.kind = spicrm_pkg::KIND_NONE;
    endcase
  end

  assign in_ready_o   = (count_q != 2'd2);
  assign push         = in_valid_i && in_ready_o;
  assign item_valid_o = (count_q != 2'd0);
  assign item_o       = queue_q[head_q];

  // Queue pointer bookkeeping.
  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (push) begin
      tail_d = ~tail_q;
    end
    if (item_pop_i) begin
      head_d = ~head_q;
    end
    if (push && !item_pop_i) begin
      count_d = count_q + 2'd1;
    end else if (!push && item_pop_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= 1'b0;
      tail_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  // Queue payload storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[tail_q] <= cls;
    end
  end

endmodule

/* sv/spicrm_back.sv */
// Back end: register file, receive buffer and transmit logic, with the result register.
module spicrm_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                item_valid_i,
  output logic                item_pop_o,
  input  spicrm_pkg::item_t   item_i,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output spicrm_pkg::result_t res_o
);

  logic [31:0]                  regs_q [spicrm_pkg::NREGS];
  logic [31:0]                  regs_d [spicrm_pkg::NREGS];
  logic [3:0]                   slave_q, slave_d;
  logic [7:0]                   mem [spicrm_pkg::FIFO_DEPTH];
  logic [7:0]                   mem_rdata_q;
  logic [spicrm_pkg::PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [spicrm_pkg::PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [spicrm_pkg::FILL_W-1:0] fill_q, fill_d;
  logic                         mem_we;
  spicrm_pkg::phase_e           phase_q, phase_d;
  spicrm_pkg::result_t          res_q, res_d;
  logic                         res_valid_q;
  logic                         out_free;
  logic                         commit;
  logic                         have;
  logic [31:0]                  old_v;
  logic [31:0]                  fmt;
  logic [4:0]                   nbits;
  logic [4:0]                   sh;
  logic                         found;

  assign out_free    = !res_valid_q || res_ready_i;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;
  assign have        = (slave_q < 4'(spicrm_pkg::SLAVE_COUNT));

  // Phases: fetch lets the buffer read settle; execute waits for a free result slot.
  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      spicrm_pkg::ST_FETCH: if (item_valid_i) phase_d = spicrm_pkg::ST_EXEC;
      spicrm_pkg::ST_EXEC:  if (out_free) phase_d = spicrm_pkg::ST_FETCH;
      default:              phase_d = spicrm_pkg::ST_FETCH;
    endcase
  end

  always_comb begin
    commit = 1'b0;
    unique case (phase_q)
      spicrm_pkg::ST_FETCH: commit = 1'b0;
      spicrm_pkg::ST_EXEC:  commit = out_free;
      default:              commit = 1'b0;
    endcase
  end

  assign item_pop_o = commit;

  // Execute one item against the register file and the buffer.
  always_comb begin
    regs_d   = regs_q;
    slave_d  = slave_q;
    rd_ptr_d = rd_ptr_q;
    wr_ptr_d = wr_ptr_q;
    fill_d   = fill_q;
    mem_we   = 1'b0;
    res_d    = '0;
    old_v    = '0;
    fmt      = '0;
    nbits    = '0;
    sh       = '0;
    found    = 1'b0;
    unique case (item_i.kind)
      spicrm_pkg::KIND_READ: begin
        if (item_i.addr == spicrm_pkg::R_BUF) begin
          if (fill_q != '0) begin
            rd_ptr_d = (32'(rd_ptr_q) + 32'd1 >= spicrm_pkg::FIFO_DEPTH) ? '0
                                                                          : rd_ptr_q + 1'b1;
            fill_d = fill_q - 1'b1;
            regs_d[spicrm_pkg::R_BUF] = {regs_q[spicrm_pkg::R_BUF][31:16], 8'h00, mem_rdata_q};
            if (fill_d == '0) begin
              regs_d[spicrm_pkg::R_FLG][8] = 1'b0;
            end
          end else begin
            regs_d[spicrm_pkg::R_FLG][8] = 1'b0;
          end
          res_d.read_data = regs_d[spicrm_pkg::R_BUF];
        end else if (item_i.addr < 5'(spicrm_pkg::NREGS)) begin
          res_d.read_data = regs_q[item_i.addr];
          if (item_i.addr == spicrm_pkg::R_INTVEC1 &&
              regs_q[spicrm_pkg::R_INTVEC1][5:1] == 5'h12) begin
            regs_d[spicrm_pkg::R_FLG][8] = 1'b0;
            regs_d[spicrm_pkg::R_FLG][6] = 1'b0;
          end
        end
      end
      spicrm_pkg::KIND_WRITE: begin
        if (item_i.addr < 5'(spicrm_pkg::NREGS)) begin
          unique case (item_i.addr)
            spicrm_pkg::R_GCR0: begin
              regs_d[spicrm_pkg::R_GCR0] = item_i.data;
              if (!item_i.data[0]) begin
                for (int i = 0; i < spicrm_pkg::NREGS; i++) begin
                  regs_d[i] = '0;
                end
                regs_d[spicrm_pkg::R_DEF] = spicrm_pkg::DEF_RESET;
              end
            end
            spicrm_pkg::R_GCR1: begin
              regs_d[spicrm_pkg::R_GCR1] = item_i.data;
              if (!item_i.data[24]) begin
                regs_d[spicrm_pkg::R_DAT0]       = '0;
                regs_d[spicrm_pkg::R_DAT1][7:0]  = 8'h00;
                regs_d[spicrm_pkg::R_FLG][9]     = 1'b0;
                regs_d[spicrm_pkg::R_FLG][8]     = 1'b0;
                regs_d[spicrm_pkg::R_FLG][4:1]   = 4'h0;
                regs_d[spicrm_pkg::R_INTVEC1]    = '0;
              end
            end
            spicrm_pkg::R_INT0: begin
              old_v = regs_q[spicrm_pkg::R_INT0];
              regs_d[spicrm_pkg::R_INT0] = item_i.data;
              // Rising enables raise the transmit interrupt.
              if ((item_i.data[9] && !old_v[9]) || (item_i.data[16] && !old_v[16])) begin
                regs_d[spicrm_pkg::R_FLG][9]  = 1'b1;
                regs_d[spicrm_pkg::R_INTVEC1] = spicrm_pkg::VEC_TX;
                res_d.irq_raised = 1'b1;
              end
              // Falling enables finish the transmit.
              if ((!item_i.data[9] && old_v[9]) || (!item_i.data[16] && old_v[16])) begin
                regs_d[spicrm_pkg::R_INTVEC1] = '0;
                regs_d[spicrm_pkg::R_FLG][9]  = 1'b0;
                res_d.transmit_done = have;
              end
              if (!item_i.data[8] && old_v[8]) begin
                regs_d[spicrm_pkg::R_FLG][8]  = 1'b0;
                regs_d[spicrm_pkg::R_INTVEC1] = '0;
              end
            end
            spicrm_pkg::R_FLG: begin
              regs_d[spicrm_pkg::R_FLG]     = regs_q[spicrm_pkg::R_FLG] & ~item_i.data;
              regs_d[spicrm_pkg::R_INTVEC1] = '0;
            end
            spicrm_pkg::R_PC4: begin
              regs_d[spicrm_pkg::R_PC4] = item_i.data;
              regs_d[spicrm_pkg::R_PC3] = regs_q[spicrm_pkg::R_PC3] | item_i.data;
            end
            spicrm_pkg::R_PC5: begin
              regs_d[spicrm_pkg::R_PC5] = item_i.data;
              regs_d[spicrm_pkg::R_PC3] = regs_q[spicrm_pkg::R_PC3] & ~item_i.data;
            end
            spicrm_pkg::R_DAT0, spicrm_pkg::R_DAT1: begin
              regs_d[item_i.addr] = item_i.data;
              if (regs_q[spicrm_pkg::R_GCR1][24]) begin
                regs_d[spicrm_pkg::R_FLG][9]  = 1'b0;
                regs_d[spicrm_pkg::R_INTVEC1] = '0;
                if (regs_q[spicrm_pkg::R_GCR1][1:0] == 2'd0) begin
                  fmt = regs_q[spicrm_pkg::R_FMT0];
                end else begin
                  fmt = regs_q[spicrm_pkg::R_FMT0 + {3'd0, regs_d[spicrm_pkg::R_DAT1][25:24]}];
                end
                if (fmt[4:0] < 5'd2) begin
                  nbits = 5'd8;
                end else if (fmt[4:0] > 5'd16) begin
                  nbits = 5'd16;
                end else begin
                  nbits = fmt[4:0];
                end
                if (regs_q[spicrm_pkg::R_GCR1][1:0] == 2'd3 && have) begin
                  res_d.cs_assert     = 1'b1;
                  res_d.tx_valid      = 1'b1;
                  res_d.tx_data       = item_i.data[15:0];
                  res_d.tx_byte_count = nbits[4:3];
                  res_d.cs_deassert   = !regs_d[spicrm_pkg::R_DAT1][28];
                end
                if (regs_q[spicrm_pkg::R_INT0][9]) begin
                  regs_d[spicrm_pkg::R_FLG][9]  = 1'b1;
                  regs_d[spicrm_pkg::R_INTVEC1] = spicrm_pkg::VEC_TX;
                  res_d.irq_raised = 1'b1;
                end
              end
            end
            spicrm_pkg::R_DEF: begin
              regs_d[spicrm_pkg::R_DEF] = item_i.data;
              slave_d = spicrm_pkg::SLAVE_NONE;
              for (int i = 0; i < spicrm_pkg::SLAVE_COUNT; i++) begin
                if (item_i.data[i] && !found) begin
                  slave_d = 4'(i);
                  found   = 1'b1;
                end
              end
            end
            default: begin
              regs_d[item_i.addr] = item_i.data;
            end
          endcase
        end
      end
      spicrm_pkg::KIND_BYTE: begin
        if (item_i.lane != 2'd0) begin
          sh = {item_i.lane, 3'b000};
          old_v = regs_q[spicrm_pkg::R_DAT1];
          regs_d[spicrm_pkg::R_DAT1] = (old_v & ~(32'hFF << sh)) |
                                       ({24'd0, item_i.data[7:0]} << sh);
          res_d.cs_deassert = old_v[28] && !regs_d[spicrm_pkg::R_DAT1][28] && have;
        end
      end
      spicrm_pkg::KIND_RX: begin
        if (32'(fill_q) < spicrm_pkg::FIFO_DEPTH) begin
          mem_we   = 1'b1;
          wr_ptr_d = (32'(wr_ptr_q) + 32'd1 >= spicrm_pkg::FIFO_DEPTH) ? '0 : wr_ptr_q + 1'b1;
          fill_d   = fill_q + 1'b1;
        end
        if (regs_q[spicrm_pkg::R_INT0][8] || regs_q[spicrm_pkg::R_INT0][16]) begin
          regs_d[spicrm_pkg::R_FLG][8]  = 1'b1;
          regs_d[spicrm_pkg::R_INTVEC1] = spicrm_pkg::VEC_RX;
          res_d.irq_raised = 1'b1;
        end
      end
      spicrm_pkg::KIND_RXEND: begin
        if (regs_q[spicrm_pkg::R_INT0][8]) begin
          regs_d[spicrm_pkg::R_FLG][8]  = 1'b1;
          regs_d[spicrm_pkg::R_INTVEC1] = spicrm_pkg::VEC_RX;
          res_d.irq_raised = 1'b1;
        end
      end
      default: begin
        res_d = '0;
      end
    endcase
    res_d.slave_select = slave_d;
  end

  // Control and architectural state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= spicrm_pkg::ST_FETCH;
      res_valid_q <= 1'b0;
      slave_q     <= spicrm_pkg::SLAVE_NONE;
      rd_ptr_q    <= '0;
      wr_ptr_q    <= '0;
      fill_q      <= '0;
      for (int i = 0; i < spicrm_pkg::NREGS; i++) begin
        regs_q[i] <= (i == int'(spicrm_pkg::R_DEF)) ? spicrm_pkg::DEF_RESET : '0;
      end
    end else begin
      phase_q <= phase_d;
      if (commit) begin
        res_valid_q <= 1'b1;
        slave_q     <= slave_d;
        rd_ptr_q    <= rd_ptr_d;
        wr_ptr_q    <= wr_ptr_d;
        fill_q      <= fill_d;
        regs_q      <= regs_d;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (commit) begin
      res_q <= res_d;
    end
  end

  // Receive buffer memory with registered read at the read pointer.
  always_ff @(posedge clk_i) begin
    if (commit && mem_we) begin
      mem[wr_ptr_q] <= item_i.data[7:0];
    end
    mem_rdata_q <= mem[rd_ptr_q];
  end

endmodule

/* sv/spi_controller_register_model_top.sv */
// A transfer in passes through the front-end queue and the back end's fetch and execute
// phases before it is registered in the result register. The back end finishes each item
// before it takes the next, waiting in the fetch phase on the buffer memory's registered read.
// The two-entry queue and the result register let each side stall on its own.
// Reset is asynchronous and active low; it clears control state and the registers
// (default select reads 0xFF, no slave selected); the buffer memory is not cleared.
module spi_controller_register_model_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // reg_addr[4:0], byte_lane[6:5], write_data[38:7], zero
  input  logic [2:0]  s_axis_tuser,  // mode[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata   // read_data[31:0], irq_raised[32], cs_assert[33],
                                     // cs_deassert[34], tx_valid[35], tx_data[51:36],
                                     // tx_byte_count[53:52], transmit_done[54],
                                     // slave_select[58:55], zero
);

  spicrm_pkg::item_t   item;
  logic                item_valid;
  logic                item_pop;
  spicrm_pkg::result_t res;

  spicrm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_mode_i   (s_axis_tuser),
    .in_addr_i   (s_axis_tdata[4:0]),
    .in_lane_i   (s_axis_tdata[6:5]),
    .in_data_i   (s_axis_tdata[38:7]),
    .item_valid_o(item_valid),
    .item_pop_i  (item_pop),
    .item_o      (item)
  );

  spicrm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_valid_i(item_valid),
    .item_pop_o  (item_pop),
    .item_i      (item),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  // Pack the result, first field lowest.
  assign m_axis_tdata = {5'd0, res.slave_select, res.transmit_done, res.tx_byte_count,
                         res.tx_data, res.tx_valid, res.cs_deassert, res.cs_assert,
                         res.irq_raised, res.read_data};

  // Slave index never exceeds the none code.
  a_slave_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[58:55] <= 4'd8))
    else $error("slave select out of range");

  // A data transfer always comes with chip select asserted.
  a_tx_cs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[35]) |-> m_axis_tdata[33])
    else $error("transmit without chip select");

  // Byte count never reaches three.
  a_byte_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[53:52] != 2'd3))
    else $error("byte count out of range");

  // No transfer and transmit-done notice in the same result.
  a_tx_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[35] && m_axis_tdata[54]))
    else $error("transfer and done together");

endmodule
